FILE: hdl/bilinear_point_sampler_assert.svh
// ----------------------------------------------------------------------------
// bilinear point sampler assertion macros
// shared concurrent assertion forms, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef BILINEAR_POINT_SAMPLER_ASSERT_SVH
`define BILINEAR_POINT_SAMPLER_ASSERT_SVH
`ifndef ASSERT_OFF
`define BPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bps property violated");
`define BPS_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bps forbidden condition seen");
`else
`define BPS_ASSERT(lbl, clk, rst_n, prop)
`define BPS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: hdl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// shared types, widths and helpers of the bilinear point sampler
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int DEF_MAX_HEIGHT   = 32;
    localparam int DEF_MAX_WIDTH    = 32;
    localparam int DEF_MAX_CHANNELS = 16;
    localparam int DEF_FRAC_BITS    = 8;

    localparam int LOC_W      = 24;
    localparam int VAL_W      = 16;
    localparam int IDX_W      = 14;
    localparam int CRD_W      = 24;
    localparam int SCALE_W    = 16;
    localparam int DIM_W      = 6;
    localparam int NCH_W      = 5;
    localparam int CH_W       = 4;
    localparam int SAT_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE        = 3'd0,
        REG_LOC_OFF_Y    = 3'd1,
        REG_LOC_OFF_X    = 3'd2,
        REG_MAP_HEIGHT   = 3'd3,
        REG_MAP_WIDTH    = 3'd4,
        REG_CHAN_COUNT   = 3'd5,
        REG_LAYOUT_NCHW  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [SCALE_W-1:0]      scale;
        logic signed [LOC_W-1:0] loc_off_y;
        logic signed [LOC_W-1:0] loc_off_x;
        logic [DIM_W-1:0]        map_height;
        logic [DIM_W-1:0]        map_width;
        logic [NCH_W-1:0]        chan_count;
        logic                    layout_nchw;
    } t_cfg;

    typedef struct packed {
        logic                    is_query;
        logic [IDX_W-1:0]        index;
        logic [VAL_W-1:0]        value;
        logic [CRD_W-1:0]        cy;
        logic [CRD_W-1:0]        cx;
    } t_cmd;

    function automatic logic [SAT_W-1:0] sat_val(input logic [DIM_W-1:0] v,
                                                 input logic [SAT_W-1:0] lo,
                                                 input logic [SAT_W-1:0] hi);
        logic [SAT_W-1:0] x;
        x = SAT_W'(v);
        if (x < lo) begin
            return lo;
        end
        if (x > hi) begin
            return hi;
        end
        return x;
    endfunction

endpackage

FILE: hdl/bilinear_point_sampler.sv
// ----------------------------------------------------------------------------
// bilinear_point_sampler
// feature map store with bilinear point sampling of all channels
// ----------------------------------------------------------------------------
// A load request passes the front and then writes the map store in the back.
// A query first passes the front, where two bit-serial dividers sharing one
// counter map both coordinates, then the back, where each channel reads its
// four corners one after another through the single port of the map store; a
// result waiting on pop holds the back. A two-entry queue lets the front work
// on the next request while the back still blends, so a stream of queries runs
// at the pace of the slower of the two. Results sit in an output register and
// are taken with pop; the store holds no defined value until loaded.
module bilinear_point_sampler #(
    parameter int MAX_HEIGHT   = bps_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH    = bps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = bps_pkg::DEF_MAX_CHANNELS,
    parameter int FRAC_BITS    = bps_pkg::DEF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic                               i_req_type,
    input  logic [bps_pkg::IDX_W-1:0]          i_element_index,
    input  logic signed [bps_pkg::VAL_W-1:0]   i_element_value,
    input  logic signed [bps_pkg::LOC_W-1:0]   i_loc_y,
    input  logic signed [bps_pkg::LOC_W-1:0]   i_loc_x,
    output logic                               empty,
    input  logic                               pop,
    output logic [bps_pkg::CH_W-1:0]           o_channel,
    output logic signed [bps_pkg::VAL_W-1:0]   o_sample_value,
    output logic                               o_last_channel
);
    import bps_pkg::*;

    t_cfg r_cfg;
    logic q_push, q_pop, q_full, q_empty;
    t_cmd q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale        <= SCALE_W'(256);
            r_cfg.loc_off_y    <= '0;
            r_cfg.loc_off_x    <= '0;
            r_cfg.map_height   <= DIM_W'(32);
            r_cfg.map_width    <= DIM_W'(32);
            r_cfg.chan_count   <= NCH_W'(16);
            r_cfg.layout_nchw  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_SCALE:        r_cfg.scale        <= i_cfg_data[SCALE_W-1:0];
                REG_LOC_OFF_Y:    r_cfg.loc_off_y    <= i_cfg_data[LOC_W-1:0];
                REG_LOC_OFF_X:    r_cfg.loc_off_x    <= i_cfg_data[LOC_W-1:0];
                REG_MAP_HEIGHT:   r_cfg.map_height   <= i_cfg_data[DIM_W-1:0];
                REG_MAP_WIDTH:    r_cfg.map_width    <= i_cfg_data[DIM_W-1:0];
                REG_CHAN_COUNT:   r_cfg.chan_count   <= i_cfg_data[NCH_W-1:0];
                REG_LAYOUT_NCHW:  r_cfg.layout_nchw  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    bps_front #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .push            (push),
        .full            (full),
        .i_req_type      (i_req_type),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_loc_y         (i_loc_y),
        .i_loc_x         (i_loc_x),
        .o_q_push        (q_push),
        .o_q_cmd         (q_in),
        .i_q_full        (q_full)
    );

    bps_cmd_q u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_empty (q_empty)
    );

    bps_back #(
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_empty      (q_empty),
        .i_q_cmd        (q_out),
        .o_q_pop        (q_pop),
        .empty          (empty),
        .pop            (pop),
        .o_channel      (o_channel),
        .o_sample_value (o_sample_value),
        .o_last_channel (o_last_channel)
    );
endmodule

FILE: hdl/bps_ram.sv
// ----------------------------------------------------------------------------
// bps_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module bps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/bps_front.sv
// ----------------------------------------------------------------------------
// bps_front
// accepts requests, maps query locations into clamped map coordinates
// ----------------------------------------------------------------------------
`include "bilinear_point_sampler_assert.svh"
module bps_front #(
    parameter int MAX_HEIGHT = bps_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = bps_pkg::DEF_MAX_WIDTH,
    parameter int FRAC_BITS  = bps_pkg::DEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bps_pkg::t_cfg                  i_cfg,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_req_type,
    input  logic [bps_pkg::IDX_W-1:0]      i_element_index,
    input  logic signed [bps_pkg::VAL_W-1:0] i_element_value,
    input  logic signed [bps_pkg::LOC_W-1:0] i_loc_y,
    input  logic signed [bps_pkg::LOC_W-1:0] i_loc_x,
    output logic                           o_q_push,
    output bps_pkg::t_cmd                  o_q_cmd,
    input  logic                           i_q_full
);
    import bps_pkg::*;

    localparam int NUM_W = LOC_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int REM_W = SCALE_W + 1;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate            r_state, n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]   r_num_y, r_num_x;
    logic [REM_W-1:0]   r_rem_y, r_rem_x;
    logic               r_is_query;
    logic [IDX_W-1:0]   r_index;
    logic [VAL_W-1:0]   r_value;

    logic               accept;
    logic signed [LOC_W:0] dy, dx;
    logic [NUM_W-1:0]   num_y, num_x;
    logic [REM_W-1:0]   div_s, sh_y, sh_x;
    logic               ge_y, ge_x;
    logic [SAT_W-1:0]   h_s, w_s;
    logic [NUM_W-1:0]   top_y, top_x, crd_y, crd_x;

    assign accept = push && (r_state == F_IDLE);
    assign full   = (r_state != F_IDLE);

    assign dy = {i_loc_y[LOC_W-1], i_loc_y} - {i_cfg.loc_off_y[LOC_W-1], i_cfg.loc_off_y};
    assign dx = {i_loc_x[LOC_W-1], i_loc_x} - {i_cfg.loc_off_x[LOC_W-1], i_cfg.loc_off_x};
    // non-positive distance truncates to at most zero and clamps to zero
    assign num_y = (dy[LOC_W] || (dy == '0)) ? '0 : {dy[LOC_W-1:0], {FRAC_BITS{1'b0}}};
    assign num_x = (dx[LOC_W] || (dx == '0)) ? '0 : {dx[LOC_W-1:0], {FRAC_BITS{1'b0}}};

    assign div_s = (i_cfg.scale == '0) ? REM_W'(1) : REM_W'(i_cfg.scale);
    assign sh_y  = {r_rem_y[REM_W-2:0], r_num_y[NUM_W-1]};
    assign sh_x  = {r_rem_x[REM_W-2:0], r_num_x[NUM_W-1]};
    assign ge_y  = (sh_y >= div_s);
    assign ge_x  = (sh_x >= div_s);

    assign h_s   = sat_val(i_cfg.map_height, SAT_W'(2), SAT_W'(MAX_HEIGHT));
    assign w_s   = sat_val(i_cfg.map_width, SAT_W'(2), SAT_W'(MAX_WIDTH));
    assign top_y = ((NUM_W'(h_s) - NUM_W'(1)) << FRAC_BITS) - NUM_W'(1);
    assign top_x = ((NUM_W'(w_s) - NUM_W'(1)) << FRAC_BITS) - NUM_W'(1);
    assign crd_y = (r_num_y > top_y) ? top_y : r_num_y;
    assign crd_x = (r_num_x > top_x) ? top_x : r_num_x;

    assign o_q_push         = (r_state == F_PUSH) && !i_q_full;
    assign o_q_cmd.is_query = r_is_query;
    assign o_q_cmd.index    = r_index;
    assign o_q_cmd.value    = r_value;
    assign o_q_cmd.cy       = CRD_W'(crd_y);
    assign o_q_cmd.cx       = CRD_W'(crd_x);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = i_req_type ? F_DIV : F_PUSH;
                end
            end
            F_DIV: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_state == F_DIV) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_query <= i_req_type;
            r_index    <= i_element_index;
            r_value    <= i_element_value;
            r_num_y    <= num_y;
            r_num_x    <= num_x;
            r_rem_y    <= '0;
            r_rem_x    <= '0;
        end else if (r_state == F_DIV) begin
            r_rem_y <= ge_y ? (sh_y - div_s) : sh_y;
            r_rem_x <= ge_x ? (sh_x - div_s) : sh_x;
            r_num_y <= {r_num_y[NUM_W-2:0], ge_y};
            r_num_x <= {r_num_x[NUM_W-2:0], ge_x};
        end
    end

    `BPS_ASSERT(a_div_count, i_clk, i_rst_n, (r_state == F_DIV) |-> (r_cnt != '0))
    `BPS_ASSERT(a_push_load, i_clk, i_rst_n, (accept && !i_req_type) |=> (r_state == F_PUSH))
    `BPS_NEVER(a_push_state, i_clk, i_rst_n, o_q_push && (r_state != F_PUSH))
endmodule

FILE: hdl/bps_cmd_q.sv
// ----------------------------------------------------------------------------
// bps_cmd_q
// two-entry request queue between the front and the back
// ----------------------------------------------------------------------------
`include "bilinear_point_sampler_assert.svh"
module bps_cmd_q (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bps_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output bps_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import bps_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    `BPS_NEVER(a_q_overflow, i_clk, i_rst_n, i_push && o_full)
    `BPS_NEVER(a_q_underflow, i_clk, i_rst_n, i_pop && o_empty)
    `BPS_NEVER(a_q_count, i_clk, i_rst_n, r_cnt == 2'd3)
endmodule

FILE: hdl/bps_back.sv
// ----------------------------------------------------------------------------
// bps_back
// executes loads and per-channel four-corner blends against the map store
// ----------------------------------------------------------------------------
`include "bilinear_point_sampler_assert.svh"
module bps_back #(
    parameter int MAX_HEIGHT   = bps_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH    = bps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = bps_pkg::DEF_MAX_CHANNELS,
    parameter int FRAC_BITS    = bps_pkg::DEF_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bps_pkg::t_cfg                    i_cfg,
    input  logic                             i_q_empty,
    input  bps_pkg::t_cmd                    i_q_cmd,
    output logic                             o_q_pop,
    output logic                             empty,
    input  logic                             pop,
    output logic [bps_pkg::CH_W-1:0]         o_channel,
    output logic signed [bps_pkg::VAL_W-1:0] o_sample_value,
    output logic                             o_last_channel
);
    import bps_pkg::*;

    localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int PW    = $clog2(MAX_HEIGHT * MAX_WIDTH);
    localparam int HWW   = $clog2(MAX_HEIGHT * MAX_WIDTH + 1);
    localparam int CNW   = $clog2(MAX_CHANNELS + 1);
    localparam int WW    = 2 * FRAC_BITS + 1;
    localparam int PRW   = WW + VAL_W + 1;
    localparam int ACC_W = 2 * FRAC_BITS + VAL_W + 2;
    localparam logic [FRAC_BITS:0]      ONE  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (2 * FRAC_BITS - 1);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_SETUP = 3'b010,
        B_RUN   = 3'b100
    } t_bstate;

    t_bstate                 r_state;
    t_cmd                    r_cmd;
    logic [WW-1:0]           r_w [4];
    logic [PW-1:0]           r_base;
    logic [HWW-1:0]          r_hw;
    logic [CNW-1:0]          r_ch;
    logic [2:0]              r_step;
    logic signed [PRW-1:0]   r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_out_v;
    logic [CH_W-1:0]         r_out_ch;
    logic [VAL_W-1:0]        r_out_val;
    logic                    r_out_last;

    logic [SAT_W-1:0]        h_s, w_s, nc_s;
    logic [FRAC_BITS-1:0]    fy, fx;
    logic [FRAC_BITS:0]      wy0, wx0;
    logic [YW-1:0]           ylo;
    logic [XW-1:0]           xlo;
    logic [1:0]              corner, wsel;
    logic [PW-1:0]           pos;
    logic [AW-1:0]           rd_addr, ram_addr;
    logic                    ram_we;
    logic [VAL_W-1:0]        ram_rdata;
    logic signed [PRW-1:0]   prod_n;
    logic signed [ACC_W-1:0] rnd;
    logic                    out_free, out_load, last_ch;

    assign h_s  = sat_val(i_cfg.map_height, SAT_W'(2), SAT_W'(MAX_HEIGHT));
    assign w_s  = sat_val(i_cfg.map_width, SAT_W'(2), SAT_W'(MAX_WIDTH));
    assign nc_s = sat_val(DIM_W'(i_cfg.chan_count), SAT_W'(1), SAT_W'(MAX_CHANNELS));

    assign fy  = r_cmd.cy[FRAC_BITS-1:0];
    assign fx  = r_cmd.cx[FRAC_BITS-1:0];
    assign wy0 = ONE - {1'b0, fy};
    assign wx0 = ONE - {1'b0, fx};
    assign ylo = r_cmd.cy[FRAC_BITS +: YW];
    assign xlo = r_cmd.cx[FRAC_BITS +: XW];

    // corner order: top-left, top-right, bottom-left, bottom-right
    assign corner  = r_step[1:0];
    assign pos     = r_base + (corner[1] ? PW'(w_s) : '0) + PW'(corner[0]);
    assign rd_addr = i_cfg.layout_nchw ? (AW'(r_ch) * AW'(r_hw) + AW'(pos))
                                       : (AW'(pos) * AW'(nc_s) + AW'(r_ch));

    assign o_q_pop  = (r_state == B_IDLE) && !i_q_empty;
    assign ram_we   = o_q_pop && !i_q_cmd.is_query && (32'(i_q_cmd.index) < DEPTH);
    assign ram_addr = ram_we ? AW'(i_q_cmd.index) : rd_addr;

    bps_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_q_cmd.value),
        .o_rdata (ram_rdata)
    );

    assign wsel    = 2'(r_step - 3'd1);
    assign prod_n  = $signed(ram_rdata) * $signed({1'b0, r_w[wsel]});
    assign rnd     = (r_acc + HALF) >>> (2 * FRAC_BITS);
    assign out_free = !r_out_v || pop;
    assign out_load = (r_state == B_RUN) && (r_step == 3'd6) && out_free;
    assign last_ch  = ((SAT_W'(r_ch) + SAT_W'(1)) == nc_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_step  <= '0;
            r_ch    <= '0;
            r_out_v <= 1'b0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (o_q_pop && i_q_cmd.is_query) begin
                        r_state <= B_SETUP;
                    end
                end
                B_SETUP: begin
                    r_state <= B_RUN;
                    r_ch    <= '0;
                    r_step  <= '0;
                end
                B_RUN: begin
                    if (r_step != 3'd6) begin
                        r_step <= r_step + 3'd1;
                    end else if (out_free) begin
                        r_step <= '0;
                        if (last_ch) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_ch <= r_ch + CNW'(1);
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_cmd.is_query) begin
            r_cmd <= i_q_cmd;
        end
        if (r_state == B_SETUP) begin
            r_w[0] <= WW'(wy0) * WW'(wx0);
            r_w[1] <= WW'(wy0) * WW'(fx);
            r_w[2] <= WW'(fy) * WW'(wx0);
            r_w[3] <= WW'(fy) * WW'(fx);
            r_base <= PW'(PW'(ylo) * PW'(w_s) + PW'(xlo));
            r_hw   <= HWW'(HWW'(h_s) * HWW'(w_s));
        end
        if (r_state == B_RUN) begin
            if ((r_step >= 3'd1) && (r_step <= 3'd4)) begin
                r_prod <= prod_n;
            end
            if ((r_step >= 3'd2) && (r_step <= 3'd5)) begin
                r_acc <= ((r_step == 3'd2) ? '0 : r_acc) + ACC_W'(r_prod);
            end
        end
        if (out_load) begin
            r_out_ch   <= CH_W'(r_ch);
            r_out_val  <= rnd[VAL_W-1:0];
            r_out_last <= last_ch;
        end
    end

    assign empty          = !r_out_v;
    assign o_channel      = r_out_ch;
    assign o_sample_value = r_out_val;
    assign o_last_channel = r_out_last;

    `BPS_NEVER(a_step_range, i_clk, i_rst_n, r_step > 3'd6)
    `BPS_NEVER(a_we_busy, i_clk, i_rst_n, ram_we && (r_state != B_IDLE))
    `BPS_NEVER(a_out_clobber, i_clk, i_rst_n, out_load && r_out_v && !pop)
    `BPS_ASSERT(a_setup_run, i_clk, i_rst_n, (r_state == B_SETUP) |=> (r_state == B_RUN))
endmodule

FILE: sim/tb_bilinear_point_sampler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bilinear_point_sampler
// fills the low part of the map store, then runs directed and random load and
// query requests under several register settings that all stay inside that
// part; a scoreboard predicts every channel sample in order and compares it
// field by field with the output
// ----------------------------------------------------------------------------
module tb_bilinear_point_sampler;
    import bps_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_HEIGHT * DEF_MAX_WIDTH * DEF_MAX_CHANNELS;
    localparam int FILL_DEPTH  = 64;

    typedef struct {
        logic [CH_W-1:0]  channel;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_sample;

    class sampler_scoreboard;
        logic [VAL_W-1:0] feature_store [STORE_DEPTH];
        int unsigned      scale_q8 = 256;
        longint           off_y = 0;
        longint           off_x = 0;
        int unsigned      rows = 32;
        int unsigned      cols = 32;
        int unsigned      chans = 16;
        bit               chan_first = 0;
        t_sample          pending_samples [$];
        int               errors = 0;

        function void write_reg(t_reg_idx r, logic [CFG_DATA_W-1:0] d);
            case (r)
                REG_SCALE:        scale_q8 = d[15:0];
                REG_LOC_OFF_Y:    off_y = longint'($signed(d[23:0]));
                REG_LOC_OFF_X:    off_x = longint'($signed(d[23:0]));
                REG_MAP_HEIGHT:   rows = d[5:0];
                REG_MAP_WIDTH:    cols = d[5:0];
                REG_CHAN_COUNT:   chans = d[4:0];
                REG_LAYOUT_NCHW:  chan_first = d[0];
                default: ;
            endcase
        endfunction

        function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint to_map(longint loc, longint off, int unsigned dim);
            longint s;
            longint q;
            longint top;
            s = (scale_q8 == 0) ? 1 : scale_q8;
            q = ((loc - off) * 256) / s;
            top = (longint'(dim - 1) << 8) - 1;
            if (q < 0) q = 0;
            if (q > top) q = top;
            return q;
        endfunction

        function longint corner(int unsigned y, int unsigned x, int unsigned c,
                                int unsigned h, int unsigned w, int unsigned nc);
            int unsigned idx;
            idx = chan_first ? (c * h * w + y * w + x) : ((y * w + x) * nc + c);
            return longint'($signed(feature_store[idx]));
        endfunction

        function void note_request(logic t, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] v,
                                   logic [LOC_W-1:0] ly, logic [LOC_W-1:0] lx);
            int unsigned h, w, nc, y0, x0;
            longint my, mx, fy, fx, wy, wx, acc, biased, r;
            t_sample s;
            if (!t) begin
                feature_store[idx] = v;
                return;
            end
            h = clip(rows, 2, DEF_MAX_HEIGHT);
            w = clip(cols, 2, DEF_MAX_WIDTH);
            nc = clip(chans, 1, DEF_MAX_CHANNELS);
            my = to_map(longint'($signed(ly)), off_y, h);
            mx = to_map(longint'($signed(lx)), off_x, w);
            y0 = 32'(my >> 8);
            x0 = 32'(mx >> 8);
            fy = my & 255;
            fx = mx & 255;
            wy = 256 - fy;
            wx = 256 - fx;
            for (int unsigned c = 0; c < nc; c++) begin
                acc = wy * (wx * corner(y0, x0, c, h, w, nc)
                    + fx * corner(y0, x0 + 1, c, h, w, nc))
                    + fy * (wx * corner(y0 + 1, x0, c, h, w, nc)
                    + fx * corner(y0 + 1, x0 + 1, c, h, w, nc));
                biased = acc + (longint'(32768) << 16) + (longint'(1) << 15);
                r = (biased >> 16) - 32768;
                s.channel = c[3:0];
                s.value = r[15:0];
                s.last = (c + 1 == nc);
                pending_samples.push_back(s);
            end
        endfunction

        function void check_result(logic [CH_W-1:0] ch, logic [VAL_W-1:0] v, logic last);
            t_sample s;
            if (pending_samples.size() == 0) begin
                $error("unexpected sample: channel %0d value %h", ch, v);
                errors++;
                return;
            end
            s = pending_samples.pop_front();
            if (ch !== s.channel) begin
                $error("channel: expected %0d actual %0d", s.channel, ch);
                errors++;
            end
            if (v !== s.value) begin
                $error("sample_value: expected %h actual %h", s.value, v);
                errors++;
            end
            if (last !== s.last) begin
                $error("last_channel: expected %0b actual %0b", s.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 0;
    logic                    i_rst_n = 0;
    logic                    i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    push = 0;
    logic                    full;
    logic                    i_req_type = 0;
    logic [IDX_W-1:0]        i_element_index = '0;
    logic signed [VAL_W-1:0] i_element_value = '0;
    logic signed [LOC_W-1:0] i_loc_y = '0;
    logic signed [LOC_W-1:0] i_loc_x = '0;
    logic                    empty;
    logic                    pop = 0;
    logic [CH_W-1:0]         o_channel;
    logic signed [VAL_W-1:0] o_sample_value;
    logic                    o_last_channel;

    sampler_scoreboard sb = new();
    bit idle_on = 0;
    int pop_stall = 0;

    bilinear_point_sampler u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_req_type(i_req_type), .i_element_index(i_element_index),
        .i_element_value(i_element_value), .i_loc_y(i_loc_y), .i_loc_x(i_loc_x),
        .empty(empty), .pop(pop),
        .o_channel(o_channel), .o_sample_value(o_sample_value),
        .o_last_channel(o_last_channel)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && push && !full)
            sb.note_request(i_req_type, i_element_index, i_element_value, i_loc_y, i_loc_x);
        if (i_rst_n && pop && !empty)
            sb.check_result(o_channel, o_sample_value, o_last_channel);
    end

    always @(negedge i_clk) begin
        if (pop_stall > 0) begin
            pop = 0;
            pop_stall--;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            pop = 0;
            pop_stall = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
        end else begin
            pop = 1;
        end
    end

    function automatic int gap_len();
        if (!idle_on || $urandom_range(0, 2) != 0) return 0;
        return ($urandom_range(0, 12) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
    endfunction

    task automatic send(logic t, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] v,
                        logic [LOC_W-1:0] ly, logic [LOC_W-1:0] lx);
        int g;
        i_req_type = t;
        i_element_index = idx;
        i_element_value = v;
        i_loc_y = ly;
        i_loc_x = lx;
        push = 1;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        push = 0;
        g = gap_len();
        repeat (g) @(negedge i_clk);
    endtask

    task automatic load(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] v);
        send(1'b0, idx, v, LOC_W'($urandom), LOC_W'($urandom));
    endtask

    task automatic query(longint ly, longint lx);
        send(1'b1, IDX_W'($urandom), VAL_W'($urandom), ly[LOC_W-1:0], lx[LOC_W-1:0]);
    endtask

    task automatic write_reg(t_reg_idx r, logic [CFG_DATA_W-1:0] d);
        i_cfg_we = 1;
        i_cfg_idx = r;
        i_cfg_data = d;
        @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 0;
        sb.write_reg(r, d);
    endtask

    task automatic drain();
        while (sb.pending_samples.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // every setting keeps height * width * channels within the filled part
    task automatic set_all(int s, int oh, int ow, int h, int w, int nc, int lay);
        write_reg(REG_SCALE, CFG_DATA_W'(s));
        write_reg(REG_LOC_OFF_Y, CFG_DATA_W'(oh));
        write_reg(REG_LOC_OFF_X, CFG_DATA_W'(ow));
        write_reg(REG_MAP_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_MAP_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_CHAN_COUNT, CFG_DATA_W'(nc));
        write_reg(REG_LAYOUT_NCHW, CFG_DATA_W'(lay));
    endtask

    task automatic random_traffic(int n);
        longint sy, sx, s;
        int unsigned h, w;
        s = (sb.scale_q8 == 0) ? 1 : sb.scale_q8;
        h = sb.clip(sb.rows, 2, DEF_MAX_HEIGHT);
        w = sb.clip(sb.cols, 2, DEF_MAX_WIDTH);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                load(IDX_W'($urandom), VAL_W'($urandom));
            end else if ($urandom_range(0, 3) == 0) begin
                query(longint'($signed(LOC_W'($urandom))), longint'($signed(LOC_W'($urandom))));
            end else begin
                sy = sb.off_y + longint'($urandom_range(0, h * 256)) * s / 256;
                sx = sb.off_x + longint'($urandom_range(0, w * 256)) * s / 256;
                query(sy, sx);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        // low part of the store written so no query can touch an unloaded entry
        for (int i = 0; i < FILL_DEPTH; i++) load(IDX_W'(i), VAL_W'($urandom));
        load(14'd0, 16'h8000);
        load(14'd4, 16'h7fff);
        load(14'd16, 16'h8000);
        load(14'd20, 16'h7fff);
        load(14'd16383, 16'hffff);
        drain();
        set_all(256, 0, 0, 4, 4, 4, 0);
        query(0, 0);
        query(128, 128);
        query(64, 192);
        query(-8388608, -8388608);
        query(8388607, 8388607);
        query(-1, 767);
        query(768, -256);
        query(255, 1);
        query(767, 767);
        drain();
        idle_on = 1;
        random_traffic(14);
        drain();
        set_all(256, 0, 0, 4, 4, 4, 1);
        random_traffic(14);
        drain();
        set_all(1, -8388608, 8388607, 2, 2, 1, 0);
        random_traffic(14);
        drain();
        set_all(65535, 8388607, -8388608, 0, 63, 0, 1);
        random_traffic(14);
        drain();
        set_all(0, 100, -100, 1, 1, 31, 0);
        random_traffic(14);
        drain();
        idle_on = 0;
        set_all(128, -300, 500, 3, 7, 3, 1);
        random_traffic(14);
        drain();
        idle_on = 1;
        repeat (4) begin
            set_all($urandom_range(64, 1024), $urandom_range(0, 4000) - 2000,
                    $urandom_range(0, 4000) - 2000, $urandom_range(2, 4),
                    $urandom_range(2, 4), $urandom_range(1, 4), $urandom_range(0, 1));
            random_traffic(14);
            drain();
        end
        if (sb.pending_samples.size() != 0) begin
            $error("samples never produced: %0d", sb.pending_samples.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("tb_bilinear_point_sampler: PASS");
        end else begin
            $display("tb_bilinear_point_sampler: FAIL");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("tb_bilinear_point_sampler: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/bps_pkg.sv
hdl/bps_ram.sv
hdl/bps_front.sv
hdl/bps_cmd_q.sv
hdl/bps_back.sv
hdl/bilinear_point_sampler.sv
sim/tb_bilinear_point_sampler.sv
